// ===== hw/rtl/fbpa_pkg.sv =====
`timescale 1ns / 1ps

package fbpa_pkg;

  // pool geometry and field widths
  localparam int NUM_BLOCKS = 1024;
  localparam int IDX_W      = 10;
  localparam int CNT_W      = 11;
  localparam int BYTES_W    = 17;
  localparam int ADDR_W     = 32;
  localparam int DATA_W     = 32;
  localparam int PADDR_W    = 4;
  localparam int SPAN_W     = BYTES_W + CNT_W;
  localparam int REM_W      = BYTES_W + IDX_W - 1;
  localparam int PROD_W     = BYTES_W + IDX_W;
  localparam int DIV_CNT_W  = $clog2(IDX_W);

  localparam logic [BYTES_W-1:0] BYTES_MIN = BYTES_W'(4);
  localparam logic [BYTES_W-1:0] BYTES_MAX = BYTES_W'(65536);

  // register word indexes on the config port
  localparam logic [1:0] REG_POOL_BASE   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BYTES = 2'd1;
  localparam logic [1:0] REG_BLK_COUNT   = 2'd2;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_EXHAUSTED = 3'd1,
    ST_RANGE     = 3'd2,
    ST_MISALIGN  = 3'd3,
    ST_DOUBLE    = 3'd4
  } status_t;

  // controller -> datapath
  typedef struct packed {
    logic    latch;
    logic    div_init;
    logic    div_step;
    logic    pop;
    logic    push_free;
    logic    sweep_step;
    logic    sweep_end;
    logic    emit;
    logic    emit_alloc;
    logic    emit_free;
    status_t status;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    op_t  op;
    logic depth_zero;
    logic out_of_range;
    logic div_last;
    logic rem_nz;
    logic map_set;
    logic sweep_last;
  } dp_sts_t;

  // block size saturated into the legal range
  function automatic logic [BYTES_W-1:0] eff_bytes(input logic [BYTES_W-1:0] b);
    logic [BYTES_W-1:0] r;
    r = b;
    if (b < BYTES_MIN) r = BYTES_MIN;
    if (b > BYTES_MAX) r = BYTES_MAX;
    return r;
  endfunction

  // block count capped at the pool size
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] c);
    logic [CNT_W-1:0] r;
    r = c;
    if (c > CNT_W'(NUM_BLOCKS)) r = CNT_W'(NUM_BLOCKS);
    return r;
  endfunction

endpackage

// ===== hw/rtl/fbpa_ram.sv =====
`timescale 1ns / 1ps

module fbpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/fbpa_ctrl.sv =====
`timescale 1ns / 1ps

module fbpa_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output fbpa_pkg::ctrl_cmd_t cmd,
  input  fbpa_pkg::dp_sts_t   sts
);

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_SWEEP  = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_ARD    = 9'b000001000,
    S_AMUL   = 9'b000010000,
    S_AADD   = 9'b000100000,
    S_FDIV   = 9'b001000000,
    S_FCHK   = 9'b010000000,
    S_FMAP   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   reset_op_r, reset_op_nxt;

  // next state and commands
  always_comb begin
    cmd          = '0;
    cmd.status   = fbpa_pkg::ST_OK;
    state_nxt    = state_r;
    reset_op_nxt = reset_op_r;
    case (state_r)
      S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (sts.sweep_last) begin
          cmd.sweep_end = 1'b1;
          cmd.emit      = reset_op_r;
          reset_op_nxt  = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.op)
          fbpa_pkg::OP_ALLOC: begin
            if (sts.depth_zero) begin
              cmd.emit   = 1'b1;
              cmd.status = fbpa_pkg::ST_EXHAUSTED;
              state_nxt  = S_IDLE;
            end else begin
              state_nxt = S_ARD;
            end
          end
          fbpa_pkg::OP_FREE: begin
            if (sts.out_of_range) begin
              cmd.emit   = 1'b1;
              cmd.status = fbpa_pkg::ST_RANGE;
              state_nxt  = S_IDLE;
            end else begin
              cmd.div_init = 1'b1;
              state_nxt    = S_FDIV;
            end
          end
          fbpa_pkg::OP_RESET: begin
            reset_op_nxt = 1'b1;
            state_nxt    = S_SWEEP;
          end
          default: begin
            cmd.emit  = 1'b1;
            state_nxt = S_IDLE;
          end
        endcase
      end
      S_ARD: begin
        state_nxt = S_AMUL;
      end
      S_AMUL: begin
        cmd.pop   = 1'b1;
        state_nxt = S_AADD;
      end
      S_AADD: begin
        cmd.emit       = 1'b1;
        cmd.emit_alloc = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FCHK;
        end
      end
      S_FCHK: begin
        if (sts.rem_nz) begin
          cmd.emit   = 1'b1;
          cmd.status = fbpa_pkg::ST_MISALIGN;
          state_nxt  = S_IDLE;
        end else begin
          state_nxt = S_FMAP;
        end
      end
      S_FMAP: begin
        cmd.emit  = 1'b1;
        state_nxt = S_IDLE;
        if (sts.map_set) begin
          cmd.push_free = 1'b1;
          cmd.emit_free = 1'b1;
        end else begin
          cmd.status = fbpa_pkg::ST_DOUBLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // power-on starts with a sweep that fills the stack and clears the map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_SWEEP;
      reset_op_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      reset_op_r <= reset_op_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_emit_not_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (state_r != S_IDLE))
    else $error("result emitted from idle");

  a_reset_op_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    reset_op_r |-> (state_r == S_SWEEP))
    else $error("pool reset pending outside sweep");

endmodule

// ===== hw/rtl/fbpa_dp.sv =====
`timescale 1ns / 1ps

module fbpa_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic [fbpa_pkg::ADDR_W-1:0]         pool_base,
  input  logic [fbpa_pkg::BYTES_W-1:0]        block_bytes,
  input  logic [fbpa_pkg::CNT_W-1:0]          blk_count,
  input  logic [1:0]                          in_func,
  input  logic [fbpa_pkg::ADDR_W-1:0]         in_free_address,
  input  fbpa_pkg::ctrl_cmd_t                 cmd,
  output fbpa_pkg::dp_sts_t                   sts,
  output logic                                out_strobe,
  output logic [2:0]                          out_status,
  output logic [fbpa_pkg::IDX_W-1:0]          out_blk_index,
  output logic [fbpa_pkg::ADDR_W-1:0]         out_block_address,
  output logic [fbpa_pkg::CNT_W-1:0]          out_free_blocks,
  output logic [fbpa_pkg::CNT_W-1:0]          out_used_blocks,
  output logic [fbpa_pkg::CNT_W-1:0]          out_peak_used
);

  localparam int IDX_W = fbpa_pkg::IDX_W;
  localparam int CNT_W = fbpa_pkg::CNT_W;

  logic [fbpa_pkg::BYTES_W-1:0]   sz;
  logic [CNT_W-1:0]               cnt;

  fbpa_pkg::op_t                  op_r;
  logic [fbpa_pkg::ADDR_W-1:0]    off_r;
  logic [fbpa_pkg::SPAN_W-1:0]    span_r;
  logic [fbpa_pkg::REM_W-1:0]     rem_r;
  logic [fbpa_pkg::REM_W-1:0]     dvs_r;
  logic [IDX_W-1:0]               q_r;
  logic [fbpa_pkg::DIV_CNT_W-1:0] div_cnt_r;
  logic [IDX_W-1:0]               idx_r;
  logic [fbpa_pkg::PROD_W-1:0]    prod_r;
  logic [CNT_W-1:0]               depth_r, depth_nxt;
  logic [CNT_W-1:0]               peak_r, peak_nxt;
  logic [IDX_W-1:0]               sweep_r;
  logic [CNT_W-1:0]               used_nxt;
  logic [CNT_W-1:0]               depth_m1;
  logic                           can_push;
  logic                           rem_ge;

  logic                           stk_we;
  logic [IDX_W-1:0]               stk_waddr, stk_wdata, stk_raddr, stk_rdata;
  logic                           map_we;
  logic [IDX_W-1:0]               map_waddr;
  logic [0:0]                     map_wdata, map_rdata;

  logic                           out_strobe_r;
  fbpa_pkg::status_t              out_status_r;
  logic [IDX_W-1:0]               out_index_r;
  logic [fbpa_pkg::ADDR_W-1:0]    out_address_r;
  logic [CNT_W-1:0]               out_free_r, out_used_r, out_peak_r;

  assign sz  = fbpa_pkg::eff_bytes(block_bytes);
  assign cnt = fbpa_pkg::eff_count(blk_count);

  // status back to the controller
  assign sts.op           = op_r;
  assign sts.depth_zero   = (depth_r == '0);
  assign sts.out_of_range = (off_r >= fbpa_pkg::ADDR_W'(span_r));
  assign sts.div_last     = (div_cnt_r == '0);
  assign sts.rem_nz       = (rem_r != '0);
  assign sts.map_set      = map_rdata[0];
  assign sts.sweep_last   = (sweep_r == IDX_W'(fbpa_pkg::NUM_BLOCKS - 1));

  assign depth_m1 = depth_r - CNT_W'(1);
  assign can_push = (depth_r < CNT_W'(fbpa_pkg::NUM_BLOCKS));
  assign rem_ge   = (rem_r >= dvs_r);

  // free stack
  assign stk_raddr = depth_m1[IDX_W-1:0];
  assign stk_we    = cmd.sweep_step || (cmd.push_free && can_push);
  assign stk_waddr = cmd.sweep_step ? sweep_r : depth_r[IDX_W-1:0];
  assign stk_wdata = cmd.sweep_step ? sweep_r : q_r;

  fbpa_ram #(
    .WIDTH (IDX_W),
    .DEPTH (fbpa_pkg::NUM_BLOCKS)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  // allocated bitmap
  assign map_we    = cmd.sweep_step || cmd.pop || cmd.push_free;
  assign map_waddr = cmd.sweep_step ? sweep_r : (cmd.pop ? stk_rdata : q_r);
  assign map_wdata = cmd.pop;

  fbpa_ram #(
    .WIDTH (1),
    .DEPTH (fbpa_pkg::NUM_BLOCKS)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (q_r),
    .rdata (map_rdata)
  );

  // counts after this step
  always_comb begin
    depth_nxt = depth_r;
    if (cmd.pop) begin
      depth_nxt = depth_m1;
    end else if (cmd.push_free && can_push) begin
      depth_nxt = depth_r + CNT_W'(1);
    end else if (cmd.sweep_end) begin
      depth_nxt = cnt;
    end
    used_nxt = (depth_nxt <= cnt) ? (cnt - depth_nxt) : '0;
    peak_nxt = peak_r;
    if (cmd.emit_alloc && (used_nxt > peak_r)) begin
      peak_nxt = used_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r      <= '0;
      peak_r       <= '0;
      sweep_r      <= '0;
      div_cnt_r    <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      depth_r      <= depth_nxt;
      peak_r       <= peak_nxt;
      out_strobe_r <= cmd.emit;
      if (cmd.sweep_step) begin
        sweep_r <= sweep_r + IDX_W'(1);
      end
      if (cmd.div_init) begin
        div_cnt_r <= fbpa_pkg::DIV_CNT_W'(IDX_W - 1);
      end else if (cmd.div_step) begin
        div_cnt_r <= div_cnt_r - fbpa_pkg::DIV_CNT_W'(1);
      end
    end
  end

  // operands, divider, address multiply and result words
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_r   <= fbpa_pkg::op_t'(in_func);
      off_r  <= in_free_address - pool_base;
      span_r <= fbpa_pkg::SPAN_W'(sz) * fbpa_pkg::SPAN_W'(cnt);
    end
    // restoring division, one quotient bit per cycle
    if (cmd.div_init) begin
      rem_r <= off_r[fbpa_pkg::REM_W-1:0];
      dvs_r <= {sz, {(IDX_W-1){1'b0}}};
      q_r   <= '0;
    end else if (cmd.div_step) begin
      if (rem_ge) begin
        rem_r <= rem_r - dvs_r;
      end
      q_r   <= {q_r[IDX_W-2:0], rem_ge};
      dvs_r <= dvs_r >> 1;
    end
    if (cmd.pop) begin
      idx_r  <= stk_rdata;
      prod_r <= fbpa_pkg::PROD_W'(stk_rdata) * fbpa_pkg::PROD_W'(sz);
    end
    if (cmd.emit) begin
      out_status_r  <= cmd.status;
      out_index_r   <= cmd.emit_alloc ? idx_r : (cmd.emit_free ? q_r : '0);
      out_address_r <= cmd.emit_alloc ? (pool_base + fbpa_pkg::ADDR_W'(prod_r)) : '0;
      out_free_r    <= depth_nxt;
      out_used_r    <= used_nxt;
      out_peak_r    <= peak_nxt;
    end
  end

  assign out_strobe        = out_strobe_r;
  assign out_status        = out_status_r;
  assign out_blk_index     = out_index_r;
  assign out_block_address = out_address_r;
  assign out_free_blocks   = out_free_r;
  assign out_used_blocks   = out_used_r;
  assign out_peak_used     = out_peak_r;

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= CNT_W'(fbpa_pkg::NUM_BLOCKS))
    else $error("stack depth past pool size");

  a_pop_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |=> (depth_r == $past(depth_r) - CNT_W'(1)))
    else $error("pop did not decrement depth");

  a_peak_cover: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.emit && cmd.emit_alloc) |=> (out_peak_used >= out_used_blocks))
    else $error("peak below used count after allocate");

endmodule

// ===== hw/rtl/fixed_block_pool_allocator.sv =====
`timescale 1ns / 1ps

// Fixed-size block pool allocator. Pulse start with in_func while busy is low;
// the result word shows up on the out_ ports for exactly one cycle, flagged by
// out_strobe, and must be taken then since there is no way to stall it. busy
// drops in the same cycle the strobe is high, so the next command can be issued
// right away. A no-op, an exhausted allocate and an out-of-range free answer
// from the decode state; a good allocate passes through the stack RAM read, the
// index-times-size multiply and the base add; a free runs the bit-serial divide
// of the offset by the block size followed by the bitmap RAM read, and a
// misaligned free is answered after the divide. Pool reset, and power-on reset,
// run a sweep that rewrites the free stack and clears the bitmap one entry per
// cycle; busy stays high throughout and a pool reset reports its result at the
// end. Registers may only be written while busy is low and no result is
// pending; a change of the block count register takes proper effect only after
// a pool reset.

module fixed_block_pool_allocator (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          in_func,
  input  logic [fbpa_pkg::ADDR_W-1:0]         in_free_address,
  // result channel
  output logic                                out_strobe,
  output logic [2:0]                          out_status,
  output logic [fbpa_pkg::IDX_W-1:0]          out_blk_index,
  output logic [fbpa_pkg::ADDR_W-1:0]         out_block_address,
  output logic [fbpa_pkg::CNT_W-1:0]          out_free_blocks,
  output logic [fbpa_pkg::CNT_W-1:0]          out_used_blocks,
  output logic [fbpa_pkg::CNT_W-1:0]          out_peak_used,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fbpa_pkg::PADDR_W-1:0]        paddr,
  input  logic [fbpa_pkg::DATA_W-1:0]         pwdata,
  output logic [fbpa_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  logic [fbpa_pkg::ADDR_W-1:0]  pool_base_r;
  logic [fbpa_pkg::BYTES_W-1:0] block_bytes_r;
  logic [fbpa_pkg::CNT_W-1:0]   blk_count_r;
  logic [1:0]                   reg_sel;
  logic                         wr_en;

  fbpa_pkg::ctrl_cmd_t          cmd;
  fbpa_pkg::dp_sts_t            sts;

  assign pready  = 1'b1;
  assign reg_sel = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;

  // config register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r   <= '0;
      block_bytes_r <= fbpa_pkg::BYTES_W'(64);
      blk_count_r   <= fbpa_pkg::CNT_W'(fbpa_pkg::NUM_BLOCKS);
    end else if (wr_en) begin
      case (reg_sel)
        fbpa_pkg::REG_POOL_BASE:   pool_base_r   <= pwdata;
        fbpa_pkg::REG_BLOCK_BYTES: block_bytes_r <= pwdata[fbpa_pkg::BYTES_W-1:0];
        fbpa_pkg::REG_BLK_COUNT:   blk_count_r   <= pwdata[fbpa_pkg::CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (reg_sel)
      fbpa_pkg::REG_POOL_BASE:   prdata = pool_base_r;
      fbpa_pkg::REG_BLOCK_BYTES: prdata = fbpa_pkg::DATA_W'(block_bytes_r);
      fbpa_pkg::REG_BLK_COUNT:   prdata = fbpa_pkg::DATA_W'(blk_count_r);
      default:                   prdata = '0;
    endcase
  end

  fbpa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  fbpa_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .pool_base         (pool_base_r),
    .block_bytes       (block_bytes_r),
    .blk_count         (blk_count_r),
    .in_func           (in_func),
    .in_free_address   (in_free_address),
    .cmd               (cmd),
    .sts               (sts),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_blk_index     (out_blk_index),
    .out_block_address (out_block_address),
    .out_free_blocks   (out_free_blocks),
    .out_used_blocks   (out_used_blocks),
    .out_peak_used     (out_peak_used)
  );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import fbpa_pkg::*;

  localparam int LIMIT_CYCLES    = 2_000_000;
  localparam int PHASES          = 8;
  localparam int WORDS_PER_PHASE = 250;

  // one result word of the allocator
  typedef struct {
    status_t              status;
    logic [IDX_W-1:0]     index;
    logic [ADDR_W-1:0]    address;
    logic [CNT_W-1:0]     free_n;
    logic [CNT_W-1:0]     used_n;
    logic [CNT_W-1:0]     peak_n;
  } pool_word_t;

  // tracks the pool state and the result words still owed by the block
  class alloc_scoreboard;
    logic [ADDR_W-1:0]  base_r;
    logic [BYTES_W-1:0] bytes_r;
    logic [CNT_W-1:0]   count_r;
    logic [IDX_W-1:0]   idx_stack [NUM_BLOCKS];
    bit                 in_use [NUM_BLOCKS];
    logic [CNT_W-1:0]   depth;
    logic [CNT_W-1:0]   peak;
    pool_word_t         awaited_words [$];
    int                 errors;

    function new();
      base_r  = '0;
      bytes_r = BYTES_W'(64);
      count_r = CNT_W'(NUM_BLOCKS);
      peak    = '0;
      errors  = 0;
      restock();
    endfunction

    function logic [BYTES_W-1:0] size_eff();
      if (bytes_r < BYTES_MIN) return BYTES_MIN;
      if (bytes_r > BYTES_MAX) return BYTES_MAX;
      return bytes_r;
    endfunction

    function logic [CNT_W-1:0] count_eff();
      if (count_r > CNT_W'(NUM_BLOCKS)) return CNT_W'(NUM_BLOCKS);
      return count_r;
    endfunction

    function logic [CNT_W-1:0] used_now();
      logic [CNT_W-1:0] c;
      c = count_eff();
      return (depth <= c) ? c - depth : '0;
    endfunction

    // slot k holds index k, nothing allocated
    function void restock();
      for (int k = 0; k < NUM_BLOCKS; k++) begin
        idx_stack[k] = IDX_W'(k);
        in_use[k]    = 1'b0;
      end
      depth = count_eff();
    endfunction

    function void set_reg(logic [1:0] sel, logic [DATA_W-1:0] val);
      case (sel)
        REG_POOL_BASE:   base_r  = val;
        REG_BLOCK_BYTES: bytes_r = val[BYTES_W-1:0];
        REG_BLK_COUNT:   count_r = val[CNT_W-1:0];
        default: ;
      endcase
    endfunction

    // apply one accepted command, queue and return the word it should produce
    function pool_word_t note_command(op_t op, logic [ADDR_W-1:0] addr);
      pool_word_t         w;
      logic [BYTES_W-1:0] sz;
      logic [ADDR_W-1:0]  off;
      logic [ADDR_W-1:0]  slot;
      logic [63:0]        span;
      w.status  = ST_OK;
      w.index   = '0;
      w.address = '0;
      sz = size_eff();
      case (op)
        OP_ALLOC: begin
          if (depth == 0) begin
            w.status = ST_EXHAUSTED;
          end else begin
            depth = depth - 1'b1;
            w.index = idx_stack[depth];
            in_use[w.index] = 1'b1;
            w.address = base_r + ADDR_W'(w.index) * ADDR_W'(sz);
            if (used_now() > peak) peak = used_now();
          end
        end
        OP_FREE: begin
          // offset wraps modulo 2^32
          off  = addr - base_r;
          span = 64'(sz) * 64'(count_eff());
          if (64'(off) >= span) begin
            w.status = ST_RANGE;
          end else if (off % ADDR_W'(sz) != 0) begin
            w.status = ST_MISALIGN;
          end else begin
            slot = off / ADDR_W'(sz);
            if (!in_use[slot[IDX_W-1:0]]) begin
              w.status = ST_DOUBLE;
            end else begin
              in_use[slot[IDX_W-1:0]] = 1'b0;
              // a push onto a full stack is dropped
              if (depth < NUM_BLOCKS) begin
                idx_stack[depth] = slot[IDX_W-1:0];
                depth = depth + 1'b1;
              end
              w.index = slot[IDX_W-1:0];
            end
          end
        end
        OP_RESET: restock();
        default: ;
      endcase
      w.free_n = depth;
      w.used_n = used_now();
      w.peak_n = peak;
      awaited_words.push_back(w);
      return w;
    endfunction

    function void check_word(pool_word_t got);
      pool_word_t want;
      if (awaited_words.size() == 0) begin
        $error("result word with no command outstanding");
        errors++;
        return;
      end
      want = awaited_words.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (got.index !== want.index) begin
        $error("blk_index: expected %0d, got %0d", want.index, got.index);
        errors++;
      end
      if (got.address !== want.address) begin
        $error("block_address: expected %h, got %h", want.address, got.address);
        errors++;
      end
      if (got.free_n !== want.free_n) begin
        $error("free_blocks: expected %0d, got %0d", want.free_n, got.free_n);
        errors++;
      end
      if (got.used_n !== want.used_n) begin
        $error("used_blocks: expected %0d, got %0d", want.used_n, got.used_n);
        errors++;
      end
      if (got.peak_n !== want.peak_n) begin
        $error("peak_used: expected %0d, got %0d", want.peak_n, got.peak_n);
        errors++;
      end
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  logic [1:0]          in_func;
  logic [ADDR_W-1:0]   in_free_address;
  logic                out_strobe;
  logic [2:0]          out_status;
  logic [IDX_W-1:0]    out_blk_index;
  logic [ADDR_W-1:0]   out_block_address;
  logic [CNT_W-1:0]    out_free_blocks;
  logic [CNT_W-1:0]    out_used_blocks;
  logic [CNT_W-1:0]    out_peak_used;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [PADDR_W-1:0]  paddr;
  logic [DATA_W-1:0]   pwdata;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  alloc_scoreboard     sb;
  logic [ADDR_W-1:0]   live_q [$];
  logic [ADDR_W-1:0]   freed_q [$];
  bit                  idle_on;
  int                  cycles = 0;

  fixed_block_pool_allocator dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_func           (in_func),
    .in_free_address   (in_free_address),
    .out_strobe        (out_strobe),
    .out_status        (out_status),
    .out_blk_index     (out_blk_index),
    .out_block_address (out_block_address),
    .out_free_blocks   (out_free_blocks),
    .out_used_blocks   (out_used_blocks),
    .out_peak_used     (out_peak_used),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result words are taken whenever the strobe is up
  always @(posedge clk) begin
    pool_word_t got;
    if (rst_n === 1'b1 && out_strobe === 1'b1) begin
      got.status  = status_t'(out_status);
      got.index   = out_blk_index;
      got.address = out_block_address;
      got.free_n  = out_free_blocks;
      got.used_n  = out_used_blocks;
      got.peak_n  = out_peak_used;
      sb.check_word(got);
    end
  end

  // drive one command word and wait until the block takes it
  task automatic issue(op_t op, logic [ADDR_W-1:0] addr);
    int gap;
    pool_word_t w;
    gap = idle_on ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start           <= 1'b1;
    in_func         <= op;
    in_free_address <= addr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    w = sb.note_command(op, addr);
    if (op == OP_ALLOC && w.status == ST_OK) live_q.push_back(w.address);
    if (op == OP_RESET) begin
      live_q.delete();
      freed_q.delete();
    end
    @(negedge clk);
  endtask

  // hold off until every owed word has come back and the block is idle
  task automatic settle();
    start <= 1'b0;
    do @(negedge clk); while (sb.awaited_words.size() != 0 || busy !== 1'b0);
  endtask

  // register write followed by a read-back
  task automatic write_reg(logic [1:0] sel, logic [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== val) begin
      $error("register %0d readback: expected %h, got %h", sel, val, prdata);
      sb.errors++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_reg(sel, val);
    @(negedge clk);
  endtask

  function automatic logic [DATA_W-1:0] pick_base();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'hFFFF_FFFF - $urandom_range(0, 4095);
      2:       return $urandom & 32'hFFFF_FF00;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [DATA_W-1:0] pick_bytes();
    case ($urandom_range(0, 6))
      0:       return $urandom_range(0, 3);
      1:       return 4 * $urandom_range(1, 64);
      2:       return $urandom_range(4, 300);
      3:       return 65536;
      4:       return $urandom_range(65537, 131071);
      default: return $urandom_range(4, 65536);
    endcase
  endfunction

  // mostly small pools so exhaustion comes up often
  function automatic logic [DATA_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return 0;
      1:       return 1;
      2, 3:    return $urandom_range(2, 8);
      4, 5:    return $urandom_range(9, 64);
      6:       return $urandom_range(65, 1023);
      7:       return 1024;
      8:       return $urandom_range(1025, 2047);
      default: return $urandom_range(1, 1024);
    endcase
  endfunction

  // mostly well-formed alloc/free traffic, with bad frees mixed in
  task automatic random_word();
    int r;
    int k;
    logic [ADDR_W-1:0]  a;
    logic [BYTES_W-1:0] sz;
    logic [63:0]        span;
    r    = $urandom_range(0, 99);
    a    = $urandom;
    sz   = sb.size_eff();
    span = 64'(sz) * 64'(sb.count_eff());
    if (r < 2) begin
      issue(OP_RESET, a);
    end else if (r < 5) begin
      issue(OP_NOP, a);
    end else if (r < 50 || (live_q.size() == 0 && r < 75)) begin
      issue(OP_ALLOC, a);
    end else if (r < 80 && live_q.size() != 0) begin
      k = $urandom_range(0, live_q.size() - 1);
      a = live_q[k];
      live_q.delete(k);
      freed_q.push_back(a);
      if (freed_q.size() > 16) void'(freed_q.pop_front());
      issue(OP_FREE, a);
    end else if (r < 86 && freed_q.size() != 0) begin
      issue(OP_FREE, freed_q[$urandom_range(0, freed_q.size() - 1)]);
    end else if (r < 91) begin
      a = (live_q.size() != 0) ? live_q[$urandom_range(0, live_q.size() - 1)] : sb.base_r;
      issue(OP_FREE, a + ADDR_W'($urandom_range(1, sz - 1)));
    end else if (r < 95) begin
      issue(OP_FREE, sb.base_r + ADDR_W'(span) + ADDR_W'($urandom_range(0, 255)));
    end else begin
      issue(OP_FREE, a);
    end
  endtask

  initial begin
    logic [ADDR_W-1:0] a;
    sb              = new();
    rst_n           = 1'b0;
    start           = 1'b0;
    in_func         = OP_NOP;
    in_free_address = '0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    idle_on         = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // default pool: top index first, good free, double, misaligned, range
    issue(OP_ALLOC, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'd1023 * 32'd64);
    issue(OP_FREE, 32'd1023 * 32'd64);
    issue(OP_FREE, 32'd1022 * 32'd64 + 32'd1);
    issue(OP_FREE, 32'd1024 * 32'd64);
    issue(OP_FREE, 32'hFFFF_FFFF);
    issue(OP_FREE, 32'h0);
    issue(OP_NOP, 32'hFFFF_FFFF);
    issue(OP_ALLOC, 32'h0);
    issue(OP_RESET, 32'hFFFF_FFFF);

    // pool wrapping past the top of the address space, oversized registers
    settle();
    write_reg(REG_POOL_BASE, 32'hFFFF_FFC0);
    write_reg(REG_BLOCK_BYTES, 32'd131071);
    write_reg(REG_BLK_COUNT, 32'd2047);
    issue(OP_RESET, 32'h0);
    issue(OP_ALLOC, 32'h0);
    a = live_q.pop_back();
    issue(OP_FREE, a);
    issue(OP_FREE, 32'hFFFF_FFC0);
    issue(OP_FREE, 32'hFFFF_FFBF);

    // empty pool, undersized block
    settle();
    write_reg(REG_BLOCK_BYTES, 32'd0);
    write_reg(REG_BLK_COUNT, 32'd0);
    issue(OP_RESET, 32'h0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'hFFFF_FFC0);

    // single block pool
    settle();
    write_reg(REG_BLOCK_BYTES, 32'd3);
    write_reg(REG_BLK_COUNT, 32'd1);
    issue(OP_RESET, 32'h0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_ALLOC, 32'h0);
    issue(OP_FREE, 32'hFFFF_FFC2);
    issue(OP_FREE, 32'hFFFF_FFC0);

    // random phases; a count change sometimes goes without a pool reset
    for (int ph = 0; ph < PHASES; ph++) begin
      settle();
      if ($urandom_range(0, 3) != 0) write_reg(REG_POOL_BASE, pick_base());
      if ($urandom_range(0, 3) != 0) write_reg(REG_BLOCK_BYTES, pick_bytes());
      if ($urandom_range(0, 3) != 0) write_reg(REG_BLK_COUNT, pick_count());
      if ($urandom_range(0, 4) != 0) issue(OP_RESET, $urandom);
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if ($urandom_range(0, 19) == 0) idle_on = !idle_on;
        if ($urandom_range(0, 99) < 2) settle();
        random_word();
      end
    end

    settle();
    repeat (20) @(negedge clk);
    if (sb.errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== fixed_block_pool_allocator.f =====
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_ctrl.sv
hw/rtl/fbpa_dp.sv
hw/rtl/fixed_block_pool_allocator.sv
tb/testbench.sv
